FILE: rtl/core/dd_odo_pkg.sv
// Shared types, constants and helper functions for the differential-drive odometry block.
`default_nettype none

package dd_odo_pkg;

  // Fraction bits of positions, displacements and velocities
  localparam int POS_FRAC_BITS = 16;
  localparam int LIN_SHIFT     = 25 - POS_FRAC_BITS;
  localparam int DIST_SHIFT    = 24 - POS_FRAC_BITS;
  localparam int HEAD_SHIFT    = 16 + POS_FRAC_BITS;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  // Divider: dividend is a 64-bit magnitude times 10^6, divisor the 48-bit interval
  localparam int NUM_W  = 84;
  localparam int DEN_W  = 48;
  localparam int QBITS  = 33;
  localparam int QCNT_W = $clog2(QBITS + 1);

  localparam logic [31:0] USEC_PER_SEC   = 32'd1000000;
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

  // CORDIC
  localparam int CORDIC_STEPS  = 14;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  localparam int CS_W          = 34;
  localparam int ANG_W         = 17;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 17'sd16384;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 17'sd32768;

  // Register indexes of the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_TICK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_BASE = 2'd1;

  typedef struct packed {
    logic [31:0] left_count;
    logic [31:0] right_count;
    logic [47:0] stamp_us;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] linear_speed;
    logic signed [31:0] turn_rate;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic               zero_interval;
  } result_t;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic             busy;
    logic             ovf;
    logic [QBITS-1:0] quot;
  } div_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LIN,
    ST_MUL_DIST,
    ST_MUL_ANG_LO,
    ST_MUL_ANG_HI,
    ST_SPD_LIN_LO,
    ST_SPD_LIN_HI,
    ST_DIV_LIN,
    ST_SPD_ANG_HI,
    ST_NUM_ANG,
    ST_CS_WAIT,
    ST_MUL_Y,
    ST_MUL_HEAD,
    ST_HEAD_CAP,
    ST_WAIT_LIN,
    ST_WAIT_ANG
  } state_t;

  // Arctangent of 2^-i in heading units
  function automatic logic signed [ANG_W-1:0] atan_unit(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      4'd0:    r = 17'sd8192;
      4'd1:    r = 17'sd4836;
      4'd2:    r = 17'sd2555;
      4'd3:    r = 17'sd1297;
      4'd4:    r = 17'sd651;
      4'd5:    r = 17'sd326;
      4'd6:    r = 17'sd163;
      4'd7:    r = 17'sd81;
      4'd8:    r = 17'sd41;
      4'd9:    r = 17'sd20;
      4'd10:   r = 17'sd10;
      4'd11:   r = 17'sd5;
      4'd12:   r = 17'sd3;
      4'd13:   r = 17'sd1;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

  // Apply a sign to a magnitude and clamp to signed 32 bits
  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic [63:0] n;
    n = 64'd0 - mag;
    if (neg) begin
      return (mag > 64'h8000_0000) ? 32'h8000_0000 : n[31:0];
    end
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dd_odo_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module dd_odo_mul (
  input  wire logic                                    clk,
  input  wire logic signed [dd_odo_pkg::MUL_W-1:0]     a,
  input  wire logic signed [dd_odo_pkg::MUL_W-1:0]     b,
  output      logic signed [dd_odo_pkg::PROD_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

FILE: rtl/core/dd_odo_div.sv
// Restoring divider, one quotient bit per cycle, with overflow detect.
`default_nettype none

module dd_odo_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [dd_odo_pkg::NUM_W-1:0]      num,
  input  wire logic [dd_odo_pkg::DEN_W-1:0]      den,
  output      dd_odo_pkg::div_res_t              res
);

  localparam int QB = dd_odo_pkg::QBITS;
  localparam int DW = dd_odo_pkg::DEN_W;
  localparam int NW = dd_odo_pkg::NUM_W;

  logic [DW-1:0]                  rem;
  logic [DW-1:0]                  dvs;
  logic [QB-1:0]                  low;
  logic [QB-1:0]                  quot;
  logic [dd_odo_pkg::QCNT_W-1:0]  cnt;
  logic                           busy;
  logic                           ovf;
  logic [DW:0]                    trial;
  logic                           fits;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, low[QB-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (ovf || cnt == '0)) begin
      busy <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      ovf  <= num[NW-1:QB] >= {{(NW-QB-DW){1'b0}}, den};
      rem  <= num[QB+DW-1:QB];
      low  <= num[QB-1:0];
      dvs  <= den;
      quot <= '0;
      cnt  <= dd_odo_pkg::QCNT_W'(QB);
    end else if (busy && !ovf && cnt != '0) begin
      rem  <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      quot <= {quot[QB-2:0], fits};
      low  <= {low[QB-2:0], 1'b0};
      cnt  <= cnt - 1'b1;
    end
  end

  assign res.busy = busy;
  assign res.ovf  = ovf;
  assign res.quot = quot;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("divider started while busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= dd_odo_pkg::QCNT_W'(QB)) else $error("divider count out of range");
  a_done: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == '0 && !start) |=> !busy) else $error("divider failed to finish");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/dd_odo_cordic.sv
// Iterative CORDIC giving cosine and sine of the heading, one rotation per cycle.
`default_nettype none

module dd_odo_cordic (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [15:0]                           heading,
  output      logic signed [dd_odo_pkg::CS_W-1:0]    cos_val,
  output      logic signed [dd_odo_pkg::CS_W-1:0]    sin_val,
  output      logic                                  done
);

  localparam int W  = dd_odo_pkg::CS_W;
  localparam int AW = dd_odo_pkg::ANG_W;
  localparam int SW = dd_odo_pkg::STEP_W;

  logic signed [W-1:0]  x, y, xs, ys, xn, yn, xneg, yneg;
  logic signed [AW-1:0] z, zn, hz, hz_fold, atan;
  logic [SW-1:0]        step;
  logic                 flip, flip_in, busy, last;

  // Quadrant folding of the start angle
  always_comb begin
    hz      = {heading[15], heading};
    hz_fold = hz;
    flip_in = 1'b0;
    if (hz > dd_odo_pkg::QUARTER_TURN) begin
      hz_fold = hz - dd_odo_pkg::HALF_TURN;
      flip_in = 1'b1;
    end else if (hz < -dd_odo_pkg::QUARTER_TURN) begin
      hz_fold = hz + dd_odo_pkg::HALF_TURN;
      flip_in = 1'b1;
    end
  end

  // One rotation; shifts truncate toward zero
  always_comb begin
    xneg = -x;
    yneg = -y;
    xs   = x[W-1] ? -(xneg >>> step) : (x >>> step);
    ys   = y[W-1] ? -(yneg >>> step) : (y >>> step);
    atan = dd_odo_pkg::atan_unit(step);
    if (z >= 0) begin
      xn = x - ys;
      yn = y + xs;
      zn = z - atan;
    end else begin
      xn = x + ys;
      yn = y - xs;
      zn = z + atan;
    end
    last = step == SW'(dd_odo_pkg::CORDIC_STEPS - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && last) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= dd_odo_pkg::CORDIC_GAIN;
      y    <= '0;
      z    <= hz_fold;
      flip <= flip_in;
      step <= '0;
    end else if (busy) begin
      x    <= (last && flip) ? -xn : xn;
      y    <= (last && flip) ? -yn : yn;
      z    <= zn;
      step <= step + 1'b1;
    end
  end

  assign cos_val = x;
  assign sin_val = y;

`ifndef ASSERT_OFF
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(busy && done)) else $error("cordic busy and done together");
  a_fold: assert property (@(posedge clk) disable iff (rst)
    start |=> (z <= dd_odo_pkg::QUARTER_TURN && z >= -dd_odo_pkg::QUARTER_TURN))
    else $error("cordic angle not folded");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (busy && last && !start) |=> done) else $error("cordic failed to finish");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/diff_drive_odometry_top.sv
// Top level of the differential-drive odometry block: sequencer, state and pose.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  sample   | sample_valid, sample_ready, sample   | in
//  result   | result_valid, result_ready, result   | out
//  cfg      | cfg_valid, cfg_ready, cfg_index/data | in
//
// A sample with nonzero elapsed time spends most of its time in the shared
// divider (one quotient bit per cycle, run once per speed); one with zero
// elapsed time skips the arithmetic. Reset is synchronous and clears the
// pose, previous sample and settings. The next sample is taken while a result
// waits in the output register; a stalled result stalls only the final step.
`default_nettype none

module diff_drive_odometry_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                sample_valid,
  output      logic                                sample_ready,
  input  wire dd_odo_pkg::sample_t                 sample,
  output      logic                                result_valid,
  input  wire logic                                result_ready,
  output      dd_odo_pkg::result_t                 result,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [dd_odo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                         cfg_data
);

  localparam int MW = dd_odo_pkg::MUL_W;
  localparam int PW = dd_odo_pkg::PROD_W;
  localparam int NW = dd_odo_pkg::NUM_W;

  dd_odo_pkg::state_t state, state_next;

  // Settings and persistent state
  logic [31:0] dist_per_tick, inv_base;
  logic [31:0] prev_left, prev_right;
  logic [47:0] prev_stamp;
  logic [31:0] acc_x, acc_y;
  logic [15:0] acc_heading;

  // Per-sample working registers
  logic [32:0] sum_abs, diff_abs;
  logic        sum_neg, diff_neg, zero_flag;
  logic [47:0] dt;
  logic [63:0] lin_mag, ang_mag, p_lo;
  logic [31:0] dist_hi, dx, dy, lin_out;
  logic [15:0] hmag;
  logic [NW-1:0] num_ang;

  // Shared units
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic                 div_start;
  logic [NW-1:0]        div_num;
  dd_odo_pkg::div_res_t div_res;
  logic                 cordic_start, cordic_done;
  logic signed [dd_odo_pkg::CS_W-1:0] cos_val, sin_val;

  // Combinational helpers
  logic        accept, load_out;
  logic [31:0] ul, ur;
  logic [33:0] dl, dr, sum_w, diff_w, sum_n, diff_n;
  logic [47:0] dt_w;
  logic [63:0] dist_w, div_mag;
  logic [95:0] full_w;
  logic [NW-1:0] num_w;
  logic [31:0] lin_d, ang_sat, ang_abs, spd;
  logic signed [PW-1:0] prod_adj;
  logic [63:0] head_w;

  assign accept       = sample_valid && sample_ready;
  assign sample_ready = state == dd_odo_pkg::ST_IDLE;
  assign cfg_ready    = 1'b1;

  // Deltas of the incoming sample
  always_comb begin
    ul     = sample.left_count - prev_left;
    ur     = sample.right_count - prev_right;
    dl     = {{2{ul[31]}}, ul};
    dr     = {{2{ur[31]}}, ur};
    sum_w  = dl + dr;
    diff_w = dr - dl;
    sum_n  = 34'd0 - sum_w;
    diff_n = 34'd0 - diff_w;
    dt_w   = sample.stamp_us - prev_stamp;
  end

  // Product post-processing
  always_comb begin
    dist_w   = prod[63:0] >> dd_odo_pkg::DIST_SHIFT;
    full_w   = {prod[63:0], 32'd0} + {32'd0, p_lo};
    num_w    = {prod[51:0], 32'd0} + {20'd0, p_lo};
    prod_adj = prod + {{(PW-30){1'b0}}, {30{prod[PW-1]}}};
    head_w   = prod[63:0] >> dd_odo_pkg::HEAD_SHIFT;
    lin_d    = dd_odo_pkg::sat32(sum_neg, lin_mag);
    ang_sat  = dd_odo_pkg::sat32(diff_neg, ang_mag);
    ang_abs  = diff_neg ? 32'd0 - ang_sat : ang_sat;
    div_mag  = div_res.ovf ? 64'hFFFF_FFFF_FFFF_FFFF : {31'd0, div_res.quot};
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dd_odo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, unit control and multiplier operands
  always_comb begin
    state_next   = state;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_num      = num_w;
    cordic_start = 1'b0;
    load_out     = 1'b0;
    spd          = dd_odo_pkg::sat32(diff_neg, div_mag);
    unique case (state)
      dd_odo_pkg::ST_IDLE: begin
        if (accept) begin
          cordic_start = 1'b1;
          state_next   = (dt_w == '0) ? dd_odo_pkg::ST_WAIT_ANG : dd_odo_pkg::ST_MUL_LIN;
        end
      end
      dd_odo_pkg::ST_MUL_LIN: begin
        mul_a      = {1'b0, sum_abs};
        mul_b      = {2'b0, dist_per_tick};
        state_next = dd_odo_pkg::ST_MUL_DIST;
      end
      dd_odo_pkg::ST_MUL_DIST: begin
        mul_a      = {1'b0, diff_abs};
        mul_b      = {2'b0, dist_per_tick};
        state_next = dd_odo_pkg::ST_MUL_ANG_LO;
      end
      dd_odo_pkg::ST_MUL_ANG_LO: begin
        mul_a      = {2'b0, dist_w[31:0]};
        mul_b      = {2'b0, inv_base};
        state_next = dd_odo_pkg::ST_MUL_ANG_HI;
      end
      dd_odo_pkg::ST_MUL_ANG_HI: begin
        mul_a      = {2'b0, dist_hi};
        mul_b      = {2'b0, inv_base};
        state_next = dd_odo_pkg::ST_SPD_LIN_LO;
      end
      dd_odo_pkg::ST_SPD_LIN_LO: begin
        mul_a      = {2'b0, lin_mag[31:0]};
        mul_b      = {2'b0, dd_odo_pkg::USEC_PER_SEC};
        state_next = dd_odo_pkg::ST_SPD_LIN_HI;
      end
      dd_odo_pkg::ST_SPD_LIN_HI: begin
        mul_a      = {2'b0, lin_mag[63:32]};
        mul_b      = {2'b0, dd_odo_pkg::USEC_PER_SEC};
        state_next = dd_odo_pkg::ST_DIV_LIN;
      end
      dd_odo_pkg::ST_DIV_LIN: begin
        div_start  = 1'b1;
        mul_a      = {2'b0, ang_mag[31:0]};
        mul_b      = {2'b0, dd_odo_pkg::USEC_PER_SEC};
        state_next = dd_odo_pkg::ST_SPD_ANG_HI;
      end
      dd_odo_pkg::ST_SPD_ANG_HI: begin
        mul_a      = {2'b0, ang_mag[63:32]};
        mul_b      = {2'b0, dd_odo_pkg::USEC_PER_SEC};
        state_next = dd_odo_pkg::ST_NUM_ANG;
      end
      dd_odo_pkg::ST_NUM_ANG: begin
        state_next = dd_odo_pkg::ST_CS_WAIT;
      end
      dd_odo_pkg::ST_CS_WAIT: begin
        mul_a = {{2{lin_d[31]}}, lin_d};
        mul_b = cos_val;
        if (cordic_done) begin
          state_next = dd_odo_pkg::ST_MUL_Y;
        end
      end
      dd_odo_pkg::ST_MUL_Y: begin
        mul_a      = {{2{lin_d[31]}}, lin_d};
        mul_b      = sin_val;
        state_next = dd_odo_pkg::ST_MUL_HEAD;
      end
      dd_odo_pkg::ST_MUL_HEAD: begin
        mul_a      = {2'b0, ang_abs};
        mul_b      = {2'b0, dd_odo_pkg::INV_TWO_PI_Q32};
        state_next = dd_odo_pkg::ST_HEAD_CAP;
      end
      dd_odo_pkg::ST_HEAD_CAP: begin
        state_next = dd_odo_pkg::ST_WAIT_LIN;
      end
      dd_odo_pkg::ST_WAIT_LIN: begin
        div_num = num_ang;
        if (!div_res.busy) begin
          div_start  = 1'b1;
          state_next = dd_odo_pkg::ST_WAIT_ANG;
        end
      end
      dd_odo_pkg::ST_WAIT_ANG: begin
        if (!div_res.busy && (!result_valid || result_ready)) begin
          load_out   = 1'b1;
          state_next = dd_odo_pkg::ST_IDLE;
        end
      end
      default: state_next = dd_odo_pkg::ST_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_tick <= '0;
      inv_base      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dd_odo_pkg::REG_DIST_PER_TICK:  dist_per_tick <= cfg_data;
        dd_odo_pkg::REG_INV_WHEEL_BASE: inv_base      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Previous sample and pose
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left   <= '0;
      prev_right  <= '0;
      prev_stamp  <= '0;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
    end else begin
      if (accept) begin
        prev_left  <= sample.left_count;
        prev_right <= sample.right_count;
        prev_stamp <= sample.stamp_us;
      end
      if (load_out && !zero_flag) begin
        acc_x       <= acc_x + dx;
        acc_y       <= acc_y + dy;
        acc_heading <= diff_neg ? acc_heading - hmag : acc_heading + hmag;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (state)
      dd_odo_pkg::ST_IDLE: begin
        if (accept) begin
          sum_neg   <= sum_w[33];
          diff_neg  <= diff_w[33];
          sum_abs   <= sum_w[33] ? sum_n[32:0] : sum_w[32:0];
          diff_abs  <= diff_w[33] ? diff_n[32:0] : diff_w[32:0];
          dt        <= dt_w;
          zero_flag <= dt_w == '0;
          lin_out   <= '0;
        end
      end
      dd_odo_pkg::ST_MUL_DIST:   lin_mag <= prod[63:0] >> dd_odo_pkg::LIN_SHIFT;
      dd_odo_pkg::ST_MUL_ANG_LO: dist_hi <= dist_w[63:32];
      dd_odo_pkg::ST_MUL_ANG_HI: p_lo    <= prod[63:0];
      dd_odo_pkg::ST_SPD_LIN_LO: ang_mag <= (|full_w[95:88]) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                             : full_w[87:24];
      dd_odo_pkg::ST_SPD_LIN_HI: p_lo    <= prod[63:0];
      dd_odo_pkg::ST_SPD_ANG_HI: p_lo    <= prod[63:0];
      dd_odo_pkg::ST_NUM_ANG:    num_ang <= num_w;
      dd_odo_pkg::ST_MUL_Y:      dx      <= prod_adj[61:30];
      dd_odo_pkg::ST_MUL_HEAD:   dy      <= prod_adj[61:30];
      dd_odo_pkg::ST_HEAD_CAP:   hmag    <= head_w[15:0];
      dd_odo_pkg::ST_WAIT_LIN: begin
        if (!div_res.busy) begin
          lin_out <= dd_odo_pkg::sat32(sum_neg, div_mag);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.linear_speed  <= zero_flag ? 32'sd0 : lin_out;
      result.turn_rate     <= zero_flag ? 32'sd0 : spd;
      result.pos_x         <= zero_flag ? acc_x : acc_x + dx;
      result.pos_y         <= zero_flag ? acc_y : acc_y + dy;
      result.heading       <= zero_flag ? acc_heading
                            : (diff_neg ? acc_heading - hmag : acc_heading + hmag);
      result.zero_interval <= zero_flag;
    end
  end

  dd_odo_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  dd_odo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dt),
    .res   (div_res)
  );

  dd_odo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .heading (acc_heading),
    .cos_val (cos_val),
    .sin_val (sin_val),
    .done    (cordic_done)
  );

`ifndef ASSERT_OFF
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_res.busy) else $error("divider restarted while busy");
  a_cs_ready: assert property (@(posedge clk) disable iff (rst)
    state == dd_odo_pkg::ST_MUL_Y |-> $past(cordic_done))
    else $error("pose multiply before cordic finished");
  a_zero_spd: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.zero_interval) |-> (result.linear_speed == 0 &&
      result.turn_rate == 0)) else $error("speed nonzero on zero interval");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !load_out) |=> !result_valid)
    else $error("result transaction repeated");
  a_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && sample.stamp_us != prev_stamp) |=> state == dd_odo_pkg::ST_MUL_LIN)
    else $error("nonzero interval skipped arithmetic");
`endif

endmodule

`default_nettype wire
